// ===== hdl/idq_pkg.sv =====
// types and constants shared by the deque blocks
// no dependencies
package idq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 3;
    localparam int COUNT_W      = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_QUERY      = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_PUSH_BACK  = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_POP_BACK   = 3'd4
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic signed [DATA_W-1:0] total;
        logic [COUNT_W-1:0]       entry_count;
        logic                     rejected;
    } out_item_t;

endpackage

// ===== hdl/idq_mem.sv =====
// entry store: one write port, one read port with registered read data
// depends on idq_pkg
module idq_mem #(
    parameter int DEPTH = idq_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [idq_pkg::DATA_W-1:0]       wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [idq_pkg::DATA_W-1:0]       rd_data
);
    import idq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/idq_core.sv =====
// deque control: end pointers, count, running sum, cached end values
// depends on idq_pkg and idq_mem
module idq_core #(
    parameter int CAPACITY = idq_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  idq_pkg::in_item_t   in_item,
    input  logic                res_ready,
    output logic                res_valid,
    output idq_pkg::out_item_t  res
);
    import idq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] front_reg, front_next;
    logic [DATA_W-1:0] back_reg, back_next;
    logic              pend_front_reg, pend_front_next;

    logic              accept;
    logic              full;
    logic              empty;
    logic              rej;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;

    function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
    endfunction

    assign in_stall = (state_reg == ST_READ) || !res_ready;
    assign accept   = in_valid && !in_stall;
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign empty    = count_reg == '0;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        pend_front_next = pend_front_reg;
        rej             = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        rd_en           = 1'b0;
        rd_addr         = slot_next(head_reg);
        res_valid       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.func)
                        FN_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                rej = 1'b1;
                            end
                            else
                            begin
                                head_next  = slot_prev(head_reg);
                                wr_en      = 1'b1;
                                wr_addr    = slot_prev(head_reg);
                                count_next = count_reg + 1'b1;
                                sum_next   = sum_reg + in_item.value;
                                front_next = in_item.value;
                                if (empty)
                                begin
                                    back_next = in_item.value;
                                end
                            end
                        end
                        FN_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                rej = 1'b1;
                            end
                            else
                            begin
                                tail_next  = slot_next(tail_reg);
                                wr_en      = 1'b1;
                                wr_addr    = tail_reg;
                                count_next = count_reg + 1'b1;
                                sum_next   = sum_reg + in_item.value;
                                back_next  = in_item.value;
                                if (empty)
                                begin
                                    front_next = in_item.value;
                                end
                            end
                        end
                        FN_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                rej = 1'b1;
                            end
                            else
                            begin
                                head_next  = slot_next(head_reg);
                                count_next = count_reg - 1'b1;
                                sum_next   = sum_reg - front_reg;
                                // new front comes from the store unless it empties
                                if (count_reg != CNT_W'(1))
                                begin
                                    rd_en           = 1'b1;
                                    rd_addr         = slot_next(head_reg);
                                    pend_front_next = 1'b1;
                                    state_next      = ST_READ;
                                end
                            end
                        end
                        FN_POP_BACK:
                        begin
                            if (empty)
                            begin
                                rej = 1'b1;
                            end
                            else
                            begin
                                tail_next  = slot_prev(tail_reg);
                                count_next = count_reg - 1'b1;
                                sum_next   = sum_reg - back_reg;
                                if (count_reg != CNT_W'(1))
                                begin
                                    rd_en           = 1'b1;
                                    rd_addr         = slot_prev(slot_prev(tail_reg));
                                    pend_front_next = 1'b0;
                                    state_next      = ST_READ;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_valid = !rd_en;
                end
            end
            ST_READ:
            begin
                if (res_ready)
                begin
                    if (pend_front_reg)
                    begin
                        front_next = rd_data;
                    end
                    else
                    begin
                        back_next = rd_data;
                    end
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.front_value = (count_next == '0) ? '1 : front_next;
        res.back_value  = (count_next == '0) ? '1 : back_next;
        res.total       = sum_next;
        res.entry_count = COUNT_W'(count_next);
        res.rejected    = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        pend_front_reg <= pend_front_next;
    end

    idq_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_item.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== hdl/int_deque_with_running_sum_top.sv =====
// deque with running sum: push, pop and query items give one result item each
// throughput: 1 item per cycle for push and query while the output is not stalled;
// a pop that leaves entries holds off the next item until the new end value,
// read through the single read port of the entry store, is loaded
// reset: asynchronous, clears pointers, count, sum and output valid; store not cleared
// depends on idq_pkg and idq_core
module int_deque_with_running_sum_top #(
    parameter int CAPACITY = idq_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  idq_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output idq_pkg::out_item_t  out_item
);
    import idq_pkg::*;

    logic      res_ready;
    logic      res_valid;
    out_item_t res;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    // output register may load when empty or being taken this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    idq_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
